// File: design/embedding_gallery_match_defines.svh
// assertion macros for the gallery match block and its checker
// no dependencies; include from files that carry concurrent assertions
`ifndef EMBEDDING_GALLERY_MATCH_DEFINES_SVH
`define EMBEDDING_GALLERY_MATCH_DEFINES_SVH

// same-cycle implication, sampled on clk_i, off during reset
`define EGM_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("egm check failed");

// next-cycle implication, sampled on clk_i, off during reset
`define EGM_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("egm check failed");

`endif

// File: design/egm_pkg.sv
// shared types and constants of the embedding gallery match block
// no dependencies
package egm_pkg;

  localparam int VECTOR_DIM_DEF     = 512;
  localparam int MAX_SAMPLES_DEF    = 64;
  localparam int MAX_IDENTITIES_DEF = 64;
  localparam int ELEMENT_BITS_DEF   = 16;

  localparam int CFG_W      = 17;
  localparam int CFG_IDX_W  = 2;
  localparam int VLEN_W     = 10;
  localparam int THR_W      = 16;
  localparam int MARGIN_W   = 17;
  localparam int STATUS_W   = 3;
  localparam int ID_OUT_W   = 6;
  localparam int SIM_W      = 16;
  localparam int FRAC_STEPS = 16;

  localparam logic [VLEN_W-1:0] VLEN_RESET = 10'd512;
  localparam logic signed [SIM_W-1:0] SIM_NONE = 16'sh8000;
  localparam logic signed [SIM_W-1:0] SIM_MAX  = 16'sh7FFF;

  typedef enum logic [1:0] {
    CMD_CLEAR  = 2'd0,
    CMD_SAMPLE = 2'd1,
    CMD_QUERY  = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_VECTOR_LENGTH    = 2'd0,
    REG_ACCEPT_THRESHOLD = 2'd1,
    REG_REQUIRED_MARGIN  = 2'd2
  } reg_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_MATCH        = 3'd0,
    ST_UNKNOWN      = 3'd1,
    ST_ZERO_QUERY   = 3'd2,
    ST_ZERO_SAMPLE  = 3'd3,
    ST_LEN_MISMATCH = 3'd4,
    ST_GALLERY_FULL = 3'd5
  } status_e;

  typedef struct packed {
    logic busy;
    logic done;
  } sq_stat_t;

endpackage

// File: design/embedding_gallery_match.sv
// top level: gallery store and cosine nearest-identity search with margin
// depends on egm_pkg and egm_isqrt
//
// element beats: busy stays low between elements of a vector, so every beat is taken
// last sample element: busy stays high through the checks and the square root of the norm
// last query element: busy stays high through the score wipe and query root, while
//   the single multiply-accumulate walks every stored sample element by element
// results come out on done_o for one cycle and cannot be stalled
// reset: gallery empty, no open vector, vector_length 512, threshold and margin 0;
//   the memories are not cleared
module embedding_gallery_match import egm_pkg::*; #(
  parameter int VECTOR_DIM     = VECTOR_DIM_DEF,
  parameter int MAX_SAMPLES    = MAX_SAMPLES_DEF,
  parameter int MAX_IDENTITIES = MAX_IDENTITIES_DEF,
  parameter int ELEMENT_BITS   = ELEMENT_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // command beat
  input  logic                           start,
  output logic                           busy,
  input  logic [1:0]                     cmd_i,
  input  logic [ID_OUT_W-1:0]            identity_i,
  input  logic signed [ELEMENT_BITS-1:0] element_value_i,
  input  logic                           last_element_i,
  // configuration writes
  input  logic                           cfg_we_i,
  input  logic [CFG_IDX_W-1:0]           cfg_idx_i,
  input  logic [CFG_W-1:0]               cfg_wdata_i,
  // result beat
  output logic                           done_o,
  output logic [STATUS_W-1:0]            status_o,
  output logic [ID_OUT_W-1:0]            best_identity_o,
  output logic signed [SIM_W-1:0]        best_similarity_o,
  output logic signed [SIM_W-1:0]        second_similarity_o
);

  // widths follow from the parameters
  localparam int VA_W     = $clog2(VECTOR_DIM);
  localparam int LEN_W    = $clog2(VECTOR_DIM + 1);
  localparam int SI_W     = $clog2(MAX_SAMPLES);
  localparam int SC_W     = $clog2(MAX_SAMPLES + 1);
  localparam int ID_W     = $clog2(MAX_IDENTITIES);
  localparam int IC_W     = $clog2(MAX_IDENTITIES + 1);
  localparam int PROD_W   = 2 * ELEMENT_BITS;
  localparam int NORM_W   = PROD_W + VA_W;
  localparam int DOT_W    = NORM_W;
  localparam int ROOT_W   = (NORM_W + 1) / 2;
  localparam int SQ_W     = 2 * ROOT_W;
  localparam int DEN_W    = SQ_W;
  localparam int DV_W     = ((DOT_W > DEN_W) ? DOT_W : DEN_W) + 2;
  localparam int STEP_MAX = (ROOT_W > FRAC_STEPS) ? ROOT_W : FRAC_STEPS;
  localparam int STEP_W   = $clog2(STEP_MAX + 1);
  localparam int GA_W     = SI_W + VA_W;
  localparam int Q_W      = FRAC_STEPS + 1;
  localparam int INFO_W   = ID_W + ROOT_W;
  localparam int SENT_W   = SIM_W + 1;

  typedef enum logic [3:0] {
    S_IDLE, S_CHECK, S_ENROLL, S_CLEAR, S_QROOT, S_SINFO, S_DOT,
    S_MUL, S_DIV0, S_DIV, S_SCORE, S_UPD, S_SCAN, S_DECIDE
  } state_e;

  state_e state_q;

  // configuration
  logic [VLEN_W-1:0]          vlen_q;
  logic signed [THR_W-1:0]    thr_q;
  logic [MARGIN_W-1:0]        margin_q;

  // open vector and gallery bookkeeping
  logic [LEN_W-1:0]           pos_q, glen_q;
  logic                       ovf_q;
  logic [NORM_W-1:0]          acc_q;
  logic [1:0]                 kind_q;
  logic [SC_W-1:0]            count_q;
  logic [ID_W-1:0]            id_q;

  // search datapath
  logic [ROOT_W-1:0]          qroot_q;
  logic [SC_W-1:0]            s_q;
  logic [LEN_W-1:0]           i_q;
  logic                       rdv_q;
  logic signed [DOT_W-1:0]    dot_q;
  logic [DEN_W-1:0]           den_q, mcand_q;
  logic [ROOT_W-1:0]          mplier_q;
  logic [STEP_W-1:0]          step_q;
  logic [DV_W-1:0]            r_q;
  logic [Q_W-1:0]             q_q;
  logic                       sat_q;
  logic signed [SIM_W-1:0]    score_q;
  logic [IC_W-1:0]            j_q;
  logic [ID_W-1:0]            jd_q;
  logic                       sv_q;
  logic                       have_q, multi_q;
  logic signed [SIM_W-1:0]    best_q, second_q;
  logic [ID_W-1:0]            bid_q;

  // result registers
  logic                       done_q;
  status_e                    status_q;
  logic [ID_W-1:0]            out_id_q;
  logic signed [SIM_W-1:0]    out_best_q, out_second_q;

  // memories
  logic signed [ELEMENT_BITS-1:0] gal_mem [2**GA_W];
  logic signed [ELEMENT_BITS-1:0] qbuf_mem [2**VA_W];
  logic [INFO_W-1:0]              info_mem [MAX_SAMPLES];
  logic [SENT_W-1:0]              score_mem [MAX_IDENTITIES];
  logic signed [ELEMENT_BITS-1:0] gal_rd_q, qbuf_rd_q;
  logic [INFO_W-1:0]              info_rd_q;
  logic [SENT_W-1:0]              score_rd_q;

  // combinational helpers
  logic                           accept, drop;
  logic [LEN_W-1:0]               len_act, pos_e;
  logic                           ovf_e, in_range;
  logic [NORM_W-1:0]              acc_e;
  logic [31:0]                    id_wide;
  logic [ID_W-1:0]                id_sat;
  logic signed [ELEMENT_BITS-1:0] mul_a, mul_b;
  logic signed [PROD_W-1:0]       mul_p;
  logic                           mism;
  logic                           sq_start;
  sq_stat_t                       sq_stat;
  logic [ROOT_W-1:0]              sq_root;
  logic [ID_W-1:0]                info_id;
  logic [ROOT_W-1:0]              info_root;
  logic [ID_W-1:0]                score_raddr;
  logic                           dot_neg;
  logic [DOT_W-1:0]               dot_mag;
  logic [DV_W-1:0]                m_ext, d_ext, r_sh;
  logic [Q_W:0]                   q_inc;
  logic [Q_W-1:0]                 mag;
  logic signed [SIM_W-1:0]        score_c;
  logic                           ent_valid;
  logic signed [SIM_W-1:0]        ent_score;
  logic signed [SIM_W+1:0]        lead;
  logic                           reject;
  logic                           gal_we, qbuf_we;

  assign accept = start && !busy;
  assign busy   = (state_q != S_IDLE);

  // vector length in use, kept in 1..VECTOR_DIM
  always_comb begin
    if (vlen_q == '0) begin
      len_act = LEN_W'(1);
    end else if (32'(vlen_q) > 32'(VECTOR_DIM)) begin
      len_act = LEN_W'(VECTOR_DIM);
    end else begin
      len_act = LEN_W'(vlen_q);
    end
  end

  // a beat of the other kind drops a partial vector
  assign drop     = ((pos_q != '0) || ovf_q) && (cmd_i != kind_q);
  assign pos_e    = drop ? '0 : pos_q;
  assign ovf_e    = drop ? 1'b0 : ovf_q;
  assign acc_e    = drop ? '0 : acc_q;
  assign in_range = pos_e < len_act;

  assign id_wide = 32'(identity_i);
  assign id_sat  = (id_wide >= 32'(MAX_IDENTITIES)) ? ID_W'(MAX_IDENTITIES - 1)
                                                     : ID_W'(id_wide);

  // one multiplier: element square while loading, query times sample while searching
  assign mul_a = (state_q == S_DOT) ? qbuf_rd_q : element_value_i;
  assign mul_b = (state_q == S_DOT) ? gal_rd_q  : element_value_i;
  assign mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);

  assign mism = ovf_q || (pos_q != len_act) || ((count_q != '0) && (glen_q != len_act));

  assign sq_start = (state_q == S_CHECK) && !mism && (acc_q != '0) &&
                    ((kind_q == CMD_QUERY) || (count_q < SC_W'(MAX_SAMPLES)));

  egm_isqrt #(
    .SQ_W (SQ_W)
  ) u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sq_start),
    .n_i     (SQ_W'(acc_q)),
    .stat_o  (sq_stat),
    .root_o  (sq_root)
  );

  assign info_id   = info_rd_q[INFO_W-1:ROOT_W];
  assign info_root = info_rd_q[ROOT_W-1:0];

  // divider front end: magnitude of the dot product against qr*sr
  assign dot_neg = dot_q[DOT_W-1];
  assign dot_mag = dot_neg ? DOT_W'(-dot_q) : DOT_W'(dot_q);
  assign m_ext   = DV_W'(dot_mag);
  assign d_ext   = DV_W'(den_q);
  assign r_sh    = r_q << 1;

  // quotient to q1.15 with half-up rounding and saturation
  assign q_inc = {1'b0, q_q} + (Q_W + 1)'(1);
  assign mag   = sat_q ? (Q_W'(1) << FRAC_STEPS) : q_inc[Q_W:1];
  always_comb begin
    if (dot_neg) begin
      if (mag >= (Q_W'(1) << (SIM_W - 1))) begin
        score_c = SIM_NONE;
      end else begin
        score_c = -$signed(SIM_W'(mag));
      end
    end else begin
      if (mag > Q_W'(SIM_MAX)) begin
        score_c = SIM_MAX;
      end else begin
        score_c = $signed(SIM_W'(mag));
      end
    end
  end

  assign ent_valid = score_rd_q[SENT_W-1];
  assign ent_score = $signed(score_rd_q[SIM_W-1:0]);

  assign lead   = (SIM_W + 2)'(best_q) - (SIM_W + 2)'(second_q);
  assign reject = (best_q < thr_q) ||
                  (lead < $signed({1'b0, margin_q})) ||
                  (multi_q && (second_q >= best_q));

  // memory ports
  assign gal_we  = accept && (cmd_i == CMD_SAMPLE) && in_range &&
                   (count_q < SC_W'(MAX_SAMPLES));
  assign qbuf_we = accept && (cmd_i == CMD_QUERY) && in_range;
  assign score_raddr = (state_q == S_SCAN) ? j_q[ID_W-1:0] : info_id;

  always_ff @(posedge clk_i) begin
    if (gal_we) begin
      gal_mem[{count_q[SI_W-1:0], pos_e[VA_W-1:0]}] <= element_value_i;
    end
    gal_rd_q <= gal_mem[{s_q[SI_W-1:0], i_q[VA_W-1:0]}];
  end

  always_ff @(posedge clk_i) begin
    if (qbuf_we) begin
      qbuf_mem[pos_e[VA_W-1:0]] <= element_value_i;
    end
    qbuf_rd_q <= qbuf_mem[i_q[VA_W-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if ((state_q == S_ENROLL) && sq_stat.done) begin
      info_mem[count_q[SI_W-1:0]] <= {id_q, sq_root};
    end
    info_rd_q <= info_mem[s_q[SI_W-1:0]];
  end

  // per-identity best scores, top bit marks a score found in this search
  always_ff @(posedge clk_i) begin
    if (state_q == S_CLEAR) begin
      score_mem[j_q[ID_W-1:0]] <= '0;
    end else if ((state_q == S_UPD) && (!ent_valid || (score_q > ent_score))) begin
      score_mem[info_id] <= {1'b1, score_q};
    end
    score_rd_q <= score_mem[score_raddr];
  end

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      vlen_q       <= VLEN_RESET;
      thr_q        <= '0;
      margin_q     <= '0;
      pos_q        <= '0;
      glen_q       <= '0;
      ovf_q        <= 1'b0;
      acc_q        <= '0;
      kind_q       <= CMD_SAMPLE;
      count_q      <= '0;
      id_q         <= '0;
      qroot_q      <= '0;
      s_q          <= '0;
      i_q          <= '0;
      rdv_q        <= 1'b0;
      dot_q        <= '0;
      den_q        <= '0;
      mcand_q      <= '0;
      mplier_q     <= '0;
      step_q       <= '0;
      r_q          <= '0;
      q_q          <= '0;
      sat_q        <= 1'b0;
      score_q      <= '0;
      j_q          <= '0;
      jd_q         <= '0;
      sv_q         <= 1'b0;
      have_q       <= 1'b0;
      multi_q      <= 1'b0;
      best_q       <= SIM_NONE;
      second_q     <= SIM_NONE;
      bid_q        <= '0;
      done_q       <= 1'b0;
      status_q     <= ST_MATCH;
      out_id_q     <= '0;
      out_best_q   <= SIM_NONE;
      out_second_q <= SIM_NONE;
    end else begin
      done_q <= 1'b0;

      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          REG_VECTOR_LENGTH:    vlen_q   <= cfg_wdata_i[VLEN_W-1:0];
          REG_ACCEPT_THRESHOLD: thr_q    <= $signed(cfg_wdata_i[THR_W-1:0]);
          REG_REQUIRED_MARGIN:  margin_q <= cfg_wdata_i[MARGIN_W-1:0];
          default: ;
        endcase
      end

      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            case (cmd_i) inside
              CMD_CLEAR: begin
                count_q <= '0;
                glen_q  <= '0;
                pos_q   <= '0;
                ovf_q   <= 1'b0;
                acc_q   <= '0;
              end
              CMD_SAMPLE, CMD_QUERY: begin
                kind_q <= cmd_i;
                if (in_range) begin
                  acc_q <= acc_e + NORM_W'(mul_p);
                  pos_q <= pos_e + LEN_W'(1);
                  ovf_q <= ovf_e;
                end else begin
                  acc_q <= acc_e;
                  pos_q <= pos_e;
                  ovf_q <= 1'b1;
                end
                if (last_element_i) begin
                  id_q    <= id_sat;
                  state_q <= S_CHECK;
                end
              end
              default: ;
            endcase
          end
        end

        // vector complete: checks in priority order, then enroll or search
        S_CHECK: begin
          pos_q        <= '0;
          ovf_q        <= 1'b0;
          acc_q        <= '0;
          out_id_q     <= '0;
          out_best_q   <= SIM_NONE;
          out_second_q <= SIM_NONE;
          if (kind_q == CMD_SAMPLE) begin
            if (count_q >= SC_W'(MAX_SAMPLES)) begin
              done_q   <= 1'b1;
              status_q <= ST_GALLERY_FULL;
              state_q  <= S_IDLE;
            end else if (mism) begin
              done_q   <= 1'b1;
              status_q <= ST_LEN_MISMATCH;
              state_q  <= S_IDLE;
            end else if (acc_q == '0) begin
              done_q   <= 1'b1;
              status_q <= ST_ZERO_SAMPLE;
              state_q  <= S_IDLE;
            end else begin
              state_q <= S_ENROLL;
            end
          end else begin
            if (mism) begin
              done_q   <= 1'b1;
              status_q <= ST_LEN_MISMATCH;
              state_q  <= S_IDLE;
            end else if (acc_q == '0) begin
              done_q   <= 1'b1;
              status_q <= ST_ZERO_QUERY;
              state_q  <= S_IDLE;
            end else begin
              j_q     <= '0;
              state_q <= S_CLEAR;
            end
          end
        end

        S_ENROLL: begin
          if (sq_stat.done) begin
            if (count_q == '0) begin
              glen_q <= len_act;
            end
            count_q <= count_q + SC_W'(1);
            state_q <= S_IDLE;
          end
        end

        // wipe the per-identity scores while the query root settles
        S_CLEAR: begin
          j_q <= j_q + IC_W'(1);
          if (j_q == IC_W'(MAX_IDENTITIES - 1)) begin
            state_q <= S_QROOT;
          end
        end

        S_QROOT: begin
          if (!sq_stat.busy) begin
            qroot_q  <= sq_root;
            s_q      <= '0;
            j_q      <= '0;
            sv_q     <= 1'b0;
            have_q   <= 1'b0;
            multi_q  <= 1'b0;
            best_q   <= SIM_NONE;
            second_q <= SIM_NONE;
            bid_q    <= '0;
            state_q  <= (count_q == '0) ? S_SCAN : S_SINFO;
          end
        end

        S_SINFO: begin
          i_q     <= '0;
          rdv_q   <= 1'b0;
          dot_q   <= '0;
          state_q <= S_DOT;
        end

        // one multiply-accumulate per element, fed by registered memory reads
        S_DOT: begin
          if (i_q < len_act) begin
            i_q <= i_q + LEN_W'(1);
          end
          rdv_q <= (i_q < len_act);
          if (rdv_q) begin
            dot_q <= dot_q + DOT_W'(mul_p);
          end
          if ((i_q == len_act) && !rdv_q) begin
            den_q    <= '0;
            mcand_q  <= DEN_W'(qroot_q);
            mplier_q <= info_root;
            step_q   <= '0;
            state_q  <= S_MUL;
          end
        end

        // shift-add product of the two roots
        S_MUL: begin
          if (mplier_q[0]) begin
            den_q <= den_q + mcand_q;
          end
          mcand_q  <= mcand_q << 1;
          mplier_q <= mplier_q >> 1;
          step_q   <= step_q + STEP_W'(1);
          if (step_q == STEP_W'(ROOT_W - 1)) begin
            state_q <= S_DIV0;
          end
        end

        // integer part of the quotient: 0, 1 or saturated
        S_DIV0: begin
          step_q <= '0;
          sat_q  <= 1'b0;
          if (m_ext >= (d_ext << 1)) begin
            sat_q   <= 1'b1;
            state_q <= S_SCORE;
          end else if (m_ext >= d_ext) begin
            q_q     <= Q_W'(1);
            r_q     <= m_ext - d_ext;
            state_q <= S_DIV;
          end else begin
            q_q     <= '0;
            r_q     <= m_ext;
            state_q <= S_DIV;
          end
        end

        // restoring division, one fraction bit per cycle
        S_DIV: begin
          if (r_sh >= d_ext) begin
            r_q <= r_sh - d_ext;
            q_q <= {q_q[Q_W-2:0], 1'b1};
          end else begin
            r_q <= r_sh;
            q_q <= {q_q[Q_W-2:0], 1'b0};
          end
          step_q <= step_q + STEP_W'(1);
          if (step_q == STEP_W'(FRAC_STEPS - 1)) begin
            state_q <= S_SCORE;
          end
        end

        S_SCORE: begin
          score_q <= score_c;
          state_q <= S_UPD;
        end

        S_UPD: begin
          s_q <= s_q + SC_W'(1);
          if ((s_q + SC_W'(1)) == count_q) begin
            j_q     <= '0;
            sv_q    <= 1'b0;
            state_q <= S_SCAN;
          end else begin
            state_q <= S_SINFO;
          end
        end

        // walk identities in ascending order for best and second
        S_SCAN: begin
          if (j_q < IC_W'(MAX_IDENTITIES)) begin
            j_q <= j_q + IC_W'(1);
          end
          sv_q <= (j_q < IC_W'(MAX_IDENTITIES));
          jd_q <= j_q[ID_W-1:0];
          if (sv_q && ent_valid) begin
            if (!have_q) begin
              best_q <= ent_score;
              bid_q  <= jd_q;
              have_q <= 1'b1;
            end else begin
              multi_q <= 1'b1;
              if (ent_score > best_q) begin
                second_q <= best_q;
                best_q   <= ent_score;
                bid_q    <= jd_q;
              end else if (ent_score > second_q) begin
                second_q <= ent_score;
              end
            end
          end
          if ((j_q == IC_W'(MAX_IDENTITIES)) && !sv_q) begin
            state_q <= S_DECIDE;
          end
        end

        S_DECIDE: begin
          done_q  <= 1'b1;
          state_q <= S_IDLE;
          if (!have_q) begin
            status_q     <= ST_UNKNOWN;
            out_id_q     <= '0;
            out_best_q   <= SIM_NONE;
            out_second_q <= SIM_NONE;
          end else begin
            status_q     <= reject ? ST_UNKNOWN : ST_MATCH;
            out_id_q     <= bid_q;
            out_best_q   <= best_q;
            out_second_q <= second_q;
          end
        end

        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign done_o              = done_q;
  assign status_o            = status_q;
  assign best_identity_o     = ID_OUT_W'(out_id_q);
  assign best_similarity_o   = out_best_q;
  assign second_similarity_o = out_second_q;

endmodule

// File: design/egm_isqrt.sv
// bit-pair integer square root, one result bit per cycle
// depends on egm_pkg for the status struct
module egm_isqrt import egm_pkg::*; #(
  parameter int SQ_W = 40
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [SQ_W-1:0]       n_i,
  output sq_stat_t              stat_o,
  output logic [SQ_W/2-1:0]     root_o
);

  localparam int ROOT_W = SQ_W / 2;
  localparam int CNT_W  = $clog2(ROOT_W + 1);

  logic [SQ_W-1:0]  n_q, res_q, bit_q;
  logic [SQ_W-1:0]  trial;
  logic [CNT_W-1:0] cnt_q;
  logic             busy_q, done_q;

  assign trial = res_q + bit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      n_q    <= '0;
      res_q  <= '0;
      bit_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        n_q    <= n_i;
        res_q  <= '0;
        bit_q  <= SQ_W'(1) << (SQ_W - 2);
        cnt_q  <= '0;
        busy_q <= 1'b1;
      end else if (busy_q) begin
        if (n_q >= trial) begin
          n_q   <= n_q - trial;
          res_q <= (res_q >> 1) + bit_q;
        end else begin
          res_q <= res_q >> 1;
        end
        bit_q <= bit_q >> 2;
        cnt_q <= cnt_q + CNT_W'(1);
        if (cnt_q == CNT_W'(ROOT_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign root_o      = res_q[ROOT_W-1:0];

endmodule

// File: design/egm_checker.sv
// port-level checks of the gallery match block, bound to the top level
// depends on egm_pkg and embedding_gallery_match_defines.svh
`include "embedding_gallery_match_defines.svh"

module egm_checker import egm_pkg::*; (
  input logic                    clk_i,
  input logic                    rst_ni,
  input logic                    start,
  input logic                    busy,
  input logic [1:0]              cmd_i,
  input logic                    done_o,
  input logic [STATUS_W-1:0]     status_o,
  input logic [ID_OUT_W-1:0]     best_identity_o,
  input logic signed [SIM_W-1:0] best_similarity_o,
  input logic signed [SIM_W-1:0] second_similarity_o
);

  // a result beat never follows another directly
  `EGM_ASSERT_NXT(a_single_beat, done_o, !done_o)

  // results only come out of work the block was busy with
  `EGM_ASSERT_IMP(a_beat_after_busy, done_o, $past(busy))

  // clear and unused commands never produce a result
  `EGM_ASSERT_NXT(a_no_beat_on_clear, start && !busy && (cmd_i == CMD_CLEAR || cmd_i == CMD_NONE), !done_o)

  // error statuses carry empty identity and score fields
  `EGM_ASSERT_IMP(a_error_fields, done_o && (status_o == ST_ZERO_QUERY || status_o == ST_ZERO_SAMPLE || status_o == ST_LEN_MISMATCH || status_o == ST_GALLERY_FULL), best_identity_o == '0 && best_similarity_o == SIM_NONE && second_similarity_o == SIM_NONE)

  // a match never has the second identity ahead of the best
  `EGM_ASSERT_IMP(a_match_order, done_o && status_o == ST_MATCH, best_similarity_o >= second_similarity_o)

endmodule

bind embedding_gallery_match egm_checker u_egm_checker (
  .clk_i               (clk_i),
  .rst_ni              (rst_ni),
  .start               (start),
  .busy                (busy),
  .cmd_i               (cmd_i),
  .done_o              (done_o),
  .status_o            (status_o),
  .best_identity_o     (best_identity_o),
  .best_similarity_o   (best_similarity_o),
  .second_similarity_o (second_similarity_o)
);
